// ----- rtl/fwrap_pkg.sv -----
// ----------------------------------------------------------------------------
// fwrap_pkg
// Shared widths, defaults and codes for the FIFO with remove-at-position.
// ----------------------------------------------------------------------------
`default_nettype none

package fwrap_pkg;

  localparam int unsigned DepthDef     = 16;
  localparam int unsigned ElemWidthDef = 32;

  localparam int unsigned ActionW = 2;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned PosW    = 4;
  localparam int unsigned StatusW = 2;

  typedef enum logic [ActionW-1:0] {
    ActEnq     = 2'd0,
    ActDeq     = 2'd1,
    ActDiscard = 2'd2
  } action_e;

  typedef enum logic [StatusW-1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2,
    StRange = 2'd3
  } status_e;

endpackage

`default_nettype wire

// ----- rtl/fwrap_ram.sv -----
// ----------------------------------------------------------------------------
// fwrap_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fwrap_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(Depth)-1:0] wr_addr_i,
  input  wire logic [Width-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic      [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fifo_with_remove_at_position.sv -----
// ----------------------------------------------------------------------------
// fifo_with_remove_at_position
// Bounded FIFO in a RAM with enqueue, dequeue and discard-at-position.
// ----------------------------------------------------------------------------
// Sequence: enqueue, rejected requests and unknown actions pass SRead and
//   SOut to their result; a removal at position p with n entries first moves
//   the n-1-p later entries down over the single RAM port pair (SShRd reads,
//   SShWr writes). A new beat is taken in the cycle after the result loads.
// Reset: count cleared, sequencer idle, no result pending; RAM not cleared.
`default_nettype none

module fifo_with_remove_at_position #(
  parameter int unsigned DEPTH      = fwrap_pkg::DepthDef,
  parameter int unsigned ELEM_WIDTH = fwrap_pkg::ElemWidthDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [fwrap_pkg::ActionW-1:0]    action_i,
  input  wire logic signed [fwrap_pkg::ValueW-1:0] value_i,
  input  wire logic [fwrap_pkg::PosW-1:0]       position_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic signed [fwrap_pkg::ValueW-1:0]   head_value_o,
  output logic [$clog2(DEPTH+1)-1:0]            entry_count_o,
  output logic                                  is_empty_o,
  output logic [fwrap_pkg::StatusW-1:0]         status_o
);

  import fwrap_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    SIdle,
    SShRd,
    SShWr,
    SRead,
    SOut
  } state_e;

  state_e              state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [AW-1:0]       idx_q, idx_d;
  status_e             req_status_q, req_status_d;
  logic                out_valid_q, out_valid_d;
  logic [ValueW-1:0]   head_q, head_d;
  logic [CW-1:0]       out_count_q, out_count_d;
  logic                out_empty_q, out_empty_d;
  status_e             out_status_q, out_status_d;

  logic                  wr_en, rd_en;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [ELEM_WIDTH-1:0] wr_data, rd_data;
  logic [63:0]           val_ext;
  logic signed [ELEM_WIDTH-1:0] head_elem;
  logic signed [63:0]    head_ext;
  logic                  in_fire;

  assign in_fire   = in_valid_i && in_ready_o;
  assign val_ext   = 64'($unsigned(value_i));
  assign head_elem = rd_data;
  assign head_ext  = 64'(head_elem);

  fwrap_ram #(
    .Width(ELEM_WIDTH),
    .Depth(DEPTH)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    req_status_d = req_status_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    head_d       = head_q;
    out_count_d  = out_count_q;
    out_empty_d  = out_empty_q;
    out_status_d = out_status_q;
    wr_en        = 1'b0;
    wr_addr      = AW'(count_q);
    wr_data      = val_ext[ELEM_WIDTH-1:0];
    rd_en        = 1'b0;
    rd_addr      = '0;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          state_d      = SRead;
          req_status_d = StOk;
          unique case (action_e'(action_i))
            ActEnq: begin
              if (32'(count_q) >= DEPTH) begin
                req_status_d = StFull;
              end else begin
                wr_en   = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            ActDeq: begin
              if (count_q == '0) begin
                req_status_d = StEmpty;
              end else begin
                idx_d   = '0;
                state_d = SShRd;
              end
            end
            ActDiscard: begin
              if (32'(position_i) >= 32'(count_q)) begin
                req_status_d = StRange;
              end else begin
                idx_d   = AW'(position_i);
                state_d = SShRd;
              end
            end
            default: ;
          endcase
        end
      end
      SShRd: begin
        if ((CW'(idx_q) + 1'b1) < count_q) begin
          rd_en   = 1'b1;
          rd_addr = idx_q + 1'b1;
          state_d = SShWr;
        end else begin
          count_d = count_q - 1'b1;
          state_d = SRead;
        end
      end
      SShWr: begin
        wr_en   = 1'b1;
        wr_addr = idx_q;
        wr_data = rd_data;
        idx_d   = idx_q + 1'b1;
        state_d = SShRd;
      end
      SRead: begin
        rd_en   = 1'b1;
        state_d = SOut;
      end
      SOut: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          head_d       = (count_q == '0) ? '0 : head_ext[ValueW-1:0];
          out_count_d  = count_q;
          out_empty_d  = (count_q == '0);
          out_status_d = req_status_q;
          state_d      = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    req_status_q <= req_status_d;
    head_q       <= head_d;
    out_count_q  <= out_count_d;
    out_empty_q  <= out_empty_d;
    out_status_q <= out_status_d;
  end

  assign in_ready_o    = (state_q == SIdle);
  assign out_valid_o   = out_valid_q;
  assign head_value_o  = $signed(head_q);
  assign entry_count_o = out_count_q;
  assign is_empty_o    = out_empty_q;
  assign status_o      = out_status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= DEPTH)
    else $error("entry count above depth");

  a_enq_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && action_i == ActEnq && 32'(count_q) < DEPTH)
      |=> count_q == $past(count_q) + 1'b1)
    else $error("enqueue did not grow count");

  a_shift_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SShRd || state_q == SShWr) |-> count_q != '0)
    else $error("shift on empty queue");

  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_empty_o) |-> (head_value_o == '0 && entry_count_o == '0))
    else $error("empty beat with nonzero head or count");

  a_err_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SOut && req_status_q != StOk) |-> count_q == out_count_d)
    else $error("rejected request changed count");

endmodule

`default_nettype wire
